@@ hw/rtl/irts_pkg.sv @@
// irts_pkg: shared types and constants for the token scanner
// character codes, scanner modes, result event and token kind codes, result beat layout
// no dependencies
package irts_pkg;

    // character codes
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_DOLLAR = 8'h24;
    localparam logic [7:0] CH_PCT    = 8'h25;
    localparam logic [7:0] CH_DASH   = 8'h2D;
    localparam logic [7:0] CH_UNDER  = 8'h5F;

    // result queue geometry
    localparam int QDEPTH = 4;
    localparam int QAW    = $clog2(QDEPTH);
    localparam int QCW    = $clog2(QDEPTH + 1);
    // most results one byte can cause
    localparam int MAX_RES = 2;

    typedef enum logic [7:0] {
        MODE_IDLE      = 8'b0000_0001,
        MODE_IDENT     = 8'b0000_0010,
        MODE_NUM       = 8'b0000_0100,
        MODE_STR       = 8'b0000_1000,
        MODE_REG       = 8'b0001_0000,
        MODE_IDX_FIRST = 8'b0010_0000,
        MODE_IDX       = 8'b0100_0000,
        MODE_DONE      = 8'b1000_0000
    } t_mode;

    typedef enum logic [1:0] {
        EV_CHAR  = 2'd0,
        EV_CLOSE = 2'd1,
        EV_END   = 2'd2,
        EV_ERROR = 2'd3
    } t_event;

    typedef enum logic [2:0] {
        KIND_REG   = 3'd0,
        KIND_IDENT = 3'd1,
        KIND_NUM   = 3'd2,
        KIND_STR   = 3'd3,
        KIND_IDX   = 3'd4
    } t_kind;

    typedef struct packed {
        t_kind      kind;
        t_event     ev;
        logic [7:0] chr;
        logic       last;
    } t_result;

    // results produced by one accepted byte
    typedef struct packed {
        logic [1:0] cnt;
        t_result    res0;
        t_result    res1;
    } t_scan_out;

endpackage

@@ hw/rtl/irts_scan.sv @@
// irts_scan: scanner mode register and per-byte decode
// turns one text byte into zero, one or two result beats
// depends on irts_pkg
module irts_scan (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  logic [7:0]          i_char,
    output irts_pkg::t_scan_out o_scan
);
    import irts_pkg::*;

    typedef struct packed {
        logic    has;
        t_result res;
        t_mode   mode;
    } t_fresh;

    t_mode     r_mode;
    t_mode     n_mode;
    t_scan_out w_scan;
    t_fresh    w_fresh;

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A) || c == CH_UNDER;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic t_result mk_res(input t_event ev, input t_kind kind,
                                       input logic [7:0] c);
        t_result r;
        r.ev   = ev;
        r.kind = kind;
        r.chr  = (ev == EV_CHAR) ? c : CH_NUL;
        r.last = 1'b0;
        return r;
    endfunction

    // byte seen between tokens
    function automatic t_fresh scan_fresh(input logic [7:0] c);
        t_fresh f;
        f.has  = 1'b0;
        f.res  = mk_res(EV_END, KIND_REG, CH_NUL);
        f.mode = MODE_IDLE;
        if (is_letter(c)) begin
            f.has  = 1'b1;
            f.res  = mk_res(EV_CHAR, KIND_IDENT, c);
            f.mode = MODE_IDENT;
        end else if (is_digit(c) || c == CH_DASH) begin
            f.has  = 1'b1;
            f.res  = mk_res(EV_CHAR, KIND_NUM, c);
            f.mode = MODE_NUM;
        end else if (c == CH_QUOTE) begin
            f.mode = MODE_STR;
        end else if (c == CH_PCT) begin
            f.mode = MODE_REG;
        end else if (c == CH_DOLLAR) begin
            f.mode = MODE_IDX_FIRST;
        end else if (c == CH_SPACE || c == CH_NL) begin
            f.mode = MODE_IDLE;
        end else begin
            f.has  = 1'b1;
            f.mode = MODE_DONE;
        end
        return f;
    endfunction

    always_comb begin
        w_fresh = scan_fresh(i_char);
        w_scan  = '0;
        n_mode  = r_mode;
        unique case (r_mode)
            MODE_IDLE: begin
                w_scan.cnt  = {1'b0, w_fresh.has};
                w_scan.res0 = w_fresh.res;
                n_mode      = w_fresh.mode;
            end
            MODE_IDENT: begin
                if (is_letter(i_char) || is_digit(i_char) || i_char == CH_DASH) begin
                    w_scan.cnt  = 2'd1;
                    w_scan.res0 = mk_res(EV_CHAR, KIND_IDENT, i_char);
                end else begin
                    w_scan.cnt  = w_fresh.has ? 2'd2 : 2'd1;
                    w_scan.res0 = mk_res(EV_CLOSE, KIND_IDENT, CH_NUL);
                    w_scan.res1 = w_fresh.res;
                    n_mode      = w_fresh.mode;
                end
            end
            MODE_NUM: begin
                if (is_digit(i_char)) begin
                    w_scan.cnt  = 2'd1;
                    w_scan.res0 = mk_res(EV_CHAR, KIND_NUM, i_char);
                end else begin
                    w_scan.cnt  = w_fresh.has ? 2'd2 : 2'd1;
                    w_scan.res0 = mk_res(EV_CLOSE, KIND_NUM, CH_NUL);
                    w_scan.res1 = w_fresh.res;
                    n_mode      = w_fresh.mode;
                end
            end
            MODE_STR: begin
                if (i_char == CH_QUOTE) begin
                    w_scan.cnt  = 2'd1;
                    w_scan.res0 = mk_res(EV_CLOSE, KIND_STR, CH_NUL);
                    n_mode      = MODE_IDLE;
                end else if (i_char == CH_NUL) begin
                    // unterminated string closes, then end of text
                    w_scan.cnt  = 2'd2;
                    w_scan.res0 = mk_res(EV_CLOSE, KIND_STR, CH_NUL);
                    w_scan.res1 = mk_res(EV_END, KIND_REG, CH_NUL);
                    n_mode      = MODE_DONE;
                end else begin
                    w_scan.cnt  = 2'd1;
                    w_scan.res0 = mk_res(EV_CHAR, KIND_STR, i_char);
                end
            end
            MODE_REG: begin
                if (is_letter(i_char)) begin
                    w_scan.cnt  = 2'd1;
                    w_scan.res0 = mk_res(EV_CHAR, KIND_REG, i_char);
                end else begin
                    w_scan.cnt  = w_fresh.has ? 2'd2 : 2'd1;
                    w_scan.res0 = mk_res(EV_CLOSE, KIND_REG, CH_NUL);
                    w_scan.res1 = w_fresh.res;
                    n_mode      = w_fresh.mode;
                end
            end
            MODE_IDX_FIRST, MODE_IDX: begin
                if (r_mode == MODE_IDX_FIRST && i_char == CH_DASH) begin
                    // negative index
                    w_scan.cnt  = 2'd1;
                    w_scan.res0 = mk_res(EV_ERROR, KIND_IDX, CH_NUL);
                    n_mode      = MODE_DONE;
                end else if (is_letter(i_char) || is_digit(i_char)) begin
                    w_scan.cnt  = 2'd1;
                    w_scan.res0 = mk_res(EV_CHAR, KIND_IDX, i_char);
                    n_mode      = MODE_IDX;
                end else begin
                    w_scan.cnt  = w_fresh.has ? 2'd2 : 2'd1;
                    w_scan.res0 = mk_res(EV_CLOSE, KIND_IDX, CH_NUL);
                    w_scan.res1 = w_fresh.res;
                    n_mode      = w_fresh.mode;
                end
            end
            MODE_DONE: begin
                w_scan.cnt = 2'd0;
            end
            default: begin
                w_scan.cnt = 2'd0;
                n_mode     = MODE_DONE;
            end
        endcase
        // mark the final beat of this byte
        w_scan.res0.last = (w_scan.cnt == 2'd1);
        w_scan.res1.last = 1'b1;
    end

    assign o_scan = w_scan;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_IDLE;
        end else if (i_accept) begin
            r_mode <= n_mode;
        end
    end

endmodule

@@ hw/rtl/irts_outq.sv @@
// irts_outq: small result queue between scanner and output stream
// takes up to two beats per cycle, gives one while the reader is ready; raises space flag for a two-beat push
// depends on irts_pkg
module irts_outq (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic [1:0]        i_push_cnt,
    input  irts_pkg::t_result i_push0,
    input  irts_pkg::t_result i_push1,
    output logic              o_valid,
    output irts_pkg::t_result o_data,
    input  logic              i_ready,
    output logic              o_space
);
    import irts_pkg::*;

    t_result           r_mem [QDEPTH];
    logic [QAW-1:0]    r_wr;
    logic [QAW-1:0]    r_rd;
    logic [QCW-1:0]    r_cnt;
    logic [QCW-1:0]    n_cnt;
    logic              r_space;
    logic              w_pop;
    logic [QAW-1:0]    w_wr1;

    assign w_pop   = (r_cnt != '0) && i_ready;
    assign w_wr1   = r_wr + QAW'(1);
    assign n_cnt   = r_cnt + QCW'(i_push_cnt) - QCW'(w_pop);
    assign o_valid = (r_cnt != '0);
    assign o_data  = r_mem[r_rd];
    assign o_space = r_space;

    always_ff @(posedge i_clk) begin
        if (i_push_cnt != 2'd0) begin
            r_mem[r_wr] <= i_push0;
        end
        if (i_push_cnt == 2'd2) begin
            r_mem[w_wr1] <= i_push1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_cnt   <= '0;
            r_space <= 1'b0;
        end else begin
            r_wr    <= r_wr + QAW'(i_push_cnt);
            r_rd    <= r_rd + QAW'(w_pop);
            r_cnt   <= n_cnt;
            r_space <= (n_cnt <= QCW'(QDEPTH - MAX_RES));
        end
    end

endmodule

@@ hw/rtl/ir_token_scanner_top.sv @@
// ir_token_scanner_top: streaming lexer for a small assembly-like text format
// instantiates irts_scan (mode register and decode) and irts_outq (result queue)
// depends on irts_pkg
//
// slave channel: one text byte per beat on i_s_axis_tdata; a zero byte ends the text
// master channel: one result per beat; tdata carries the token character (zero for
//   other events), tuser carries event and token kind, tlast marks the final
//   result caused by one input byte
// each byte gives zero, one or two results; opening marks and blanks give none but
//   a close; after end of text or a negative index error all further bytes are swallowed
// queue entry: a byte's results enter the queue on its accept edge, and when the queue
//   was empty the first one is offered on the master side straight from its registers
// throughput: one byte per cycle while the receiver keeps up and the queue has room;
//   each two-result byte leaves one extra entry queued, and tready is low while three
//   or more results are waiting
// reset: synchronous active-low reset returns the scanner to idle between tokens
//   and empties the four-entry queue; tready is low during reset and stays low until
//   the space flag is first registered after it
// stalls: results wait in the queue and tready drops once fewer than two entries are free
module ir_token_scanner_top (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_axis_tvalid,
    output logic       o_s_axis_tready,
    input  logic [7:0] i_s_axis_tdata,   // [7:0] char_in
    output logic       o_m_axis_tvalid,
    input  logic       i_m_axis_tready,
    output logic [7:0] o_m_axis_tdata,   // [7:0] char_out
    output logic [4:0] o_m_axis_tuser,   // [1:0] event_res, [4:2] token_kind
    output logic       o_m_axis_tlast    // last
);
    import irts_pkg::*;

    logic      w_accept;
    logic      w_space;
    t_scan_out w_scan;
    t_result   w_out;
    logic [1:0] w_push_cnt;

    // byte taken when queue has room for two results
    assign o_s_axis_tready = w_space;
    assign w_accept        = i_s_axis_tvalid && w_space;
    assign w_push_cnt      = w_accept ? w_scan.cnt : 2'd0;

    irts_scan u_scan (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (w_accept),
        .i_char   (i_s_axis_tdata),
        .o_scan   (w_scan)
    );

    irts_outq u_outq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push_cnt (w_push_cnt),
        .i_push0    (w_scan.res0),
        .i_push1    (w_scan.res1),
        .o_valid    (o_m_axis_tvalid),
        .o_data     (w_out),
        .i_ready    (i_m_axis_tready),
        .o_space    (w_space)
    );

    // result beat onto the master side
    assign o_m_axis_tdata = w_out.chr;
    assign o_m_axis_tuser = {w_out.kind, w_out.ev};
    assign o_m_axis_tlast = w_out.last;

endmodule

@@ hw/rtl/irts_checker.sv @@
// irts_checker: port-level checks for the token scanner
// bound to ir_token_scanner_top at the end of this file
// depends on irts_pkg
module irts_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_s_axis_tready,
    input logic       o_m_axis_tvalid,
    input logic       i_m_axis_tready,
    input logic [7:0] o_m_axis_tdata,
    input logic [4:0] o_m_axis_tuser,
    input logic       o_m_axis_tlast
);
    import irts_pkg::*;

    // reset leaves no results pending and blocks input
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid && !o_s_axis_tready)
        else $error("results or ready present right after reset");

    // only character events carry a character
    a_char_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser[1:0] != EV_CHAR |-> o_m_axis_tdata == 8'h00)
        else $error("non-character event with nonzero data");

    // end of text and error are always the final result of their byte
    a_end_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && (o_m_axis_tuser[1:0] == EV_END || o_m_axis_tuser[1:0] == EV_ERROR)
        |-> o_m_axis_tlast)
        else $error("end or error result without tlast");

    // a stalled result stays offered
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata)
        && $stable(o_m_axis_tuser) && $stable(o_m_axis_tlast))
        else $error("stalled result changed");

endmodule

bind ir_token_scanner_top irts_checker u_irts_checker (.*);

@@ tb/ir_token_scanner_checker.sv @@
// ir_token_scanner_checker: watches both streams of the token scanner, predicts
// the result beats of every accepted text byte and compares them in order
// depends on irts_pkg
module ir_token_scanner_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    input  logic       i_s_tready,
    input  logic [7:0] i_s_tdata,   // [7:0] char_in
    input  logic       i_m_tvalid,
    input  logic       i_m_tready,
    input  logic [7:0] i_m_tdata,   // [7:0] char_out
    input  logic [4:0] i_m_tuser,   // [1:0] event_res, [4:2] token_kind
    input  logic       i_m_tlast,
    output int         o_fail_cnt,
    output int         o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import irts_pkg::*;

    t_mode   lex_mode = MODE_IDLE;
    t_result token_beats[$];

    function automatic logic is_letter(input logic [7:0] c);
        return (c >= "A" && c <= "Z") || (c >= "a" && c <= "z") || c == CH_UNDER;
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic void emit(input t_event ev, input t_kind kind, input logic [7:0] c);
        t_result r;
        r.ev   = ev;
        r.kind = kind;
        r.chr  = (ev == EV_CHAR) ? c : 8'h00;
        r.last = 1'b0;
        token_beats = {token_beats, r};
    endfunction

    // byte seen between tokens
    function automatic void lex_fresh(input logic [7:0] c);
        if (is_letter(c)) begin
            lex_mode = MODE_IDENT;
            emit(EV_CHAR, KIND_IDENT, c);
        end else if (is_digit(c) || c == CH_DASH) begin
            lex_mode = MODE_NUM;
            emit(EV_CHAR, KIND_NUM, c);
        end else begin
            case (c)
                CH_QUOTE:        lex_mode = MODE_STR;
                CH_PCT:          lex_mode = MODE_REG;
                CH_DOLLAR:       lex_mode = MODE_IDX_FIRST;
                CH_SPACE, CH_NL: lex_mode = MODE_IDLE;
                default: begin
                    // end of text carries kind zero
                    lex_mode = MODE_DONE;
                    emit(EV_END, KIND_REG, 8'h00);
                end
            endcase
        end
    endfunction

    function automatic void close_token(input t_kind kind, input logic [7:0] c);
        emit(EV_CLOSE, kind, 8'h00);
        lex_mode = MODE_IDLE;
        lex_fresh(c);
    endfunction

    function automatic void lex_byte(input logic [7:0] c);
        int      beats_at_start;
        t_result tail;
        beats_at_start = token_beats.size();
        case (lex_mode)
            MODE_IDLE: lex_fresh(c);
            MODE_IDENT: begin
                if (is_letter(c) || is_digit(c) || c == CH_DASH)
                    emit(EV_CHAR, KIND_IDENT, c);
                else
                    close_token(KIND_IDENT, c);
            end
            MODE_NUM: begin
                if (is_digit(c))
                    emit(EV_CHAR, KIND_NUM, c);
                else
                    close_token(KIND_NUM, c);
            end
            MODE_STR: begin
                if (c == CH_QUOTE) begin
                    emit(EV_CLOSE, KIND_STR, 8'h00);
                    lex_mode = MODE_IDLE;
                end else if (c == CH_NUL) begin
                    // unterminated string closes, then end of text
                    emit(EV_CLOSE, KIND_STR, 8'h00);
                    emit(EV_END, KIND_REG, 8'h00);
                    lex_mode = MODE_DONE;
                end else begin
                    emit(EV_CHAR, KIND_STR, c);
                end
            end
            MODE_REG: begin
                if (is_letter(c))
                    emit(EV_CHAR, KIND_REG, c);
                else
                    close_token(KIND_REG, c);
            end
            MODE_IDX_FIRST, MODE_IDX: begin
                if (lex_mode == MODE_IDX_FIRST && c == CH_DASH) begin
                    // negative index is fatal to the text
                    emit(EV_ERROR, KIND_IDX, 8'h00);
                    lex_mode = MODE_DONE;
                end else begin
                    lex_mode = MODE_IDX;
                    if (is_letter(c) || is_digit(c))
                        emit(EV_CHAR, KIND_IDX, c);
                    else
                        close_token(KIND_IDX, c);
                end
            end
            default: ;
        endcase
        if (token_beats.size() > beats_at_start) begin
            tail      = token_beats.pop_back();
            tail.last = 1'b1;
            token_beats = {token_beats, tail};
        end
    endfunction

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            lex_mode = MODE_IDLE;
            token_beats.delete();
            o_fail_cnt = 0;
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                if (token_beats.size() == 0) begin
                    $error("result beat with none pending: tuser 5'h%02h tdata 8'h%02h",
                           i_m_tuser, i_m_tdata);
                    o_fail_cnt++;
                end else begin
                    want = token_beats.pop_front();
                    if (i_m_tuser[1:0] !== want.ev) begin
                        $error("event_res: expected %0d, got %0d", want.ev, i_m_tuser[1:0]);
                        o_fail_cnt++;
                    end
                    if (i_m_tuser[4:2] !== want.kind) begin
                        $error("token_kind: expected %0d, got %0d", want.kind,
                               i_m_tuser[4:2]);
                        o_fail_cnt++;
                    end
                    if (i_m_tdata !== want.chr) begin
                        $error("char_out: expected 8'h%02h, got 8'h%02h", want.chr, i_m_tdata);
                        o_fail_cnt++;
                    end
                    if (i_m_tlast !== want.last) begin
                        $error("last: expected %0d, got %0d", want.last, i_m_tlast);
                        o_fail_cnt++;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready)
                lex_byte(i_s_tdata);
        end
        o_pending = token_beats.size();
    end

endmodule

@@ tb/ir_token_scanner_top_tb.sv @@
// ir_token_scanner_top_tb: drives one long source text into the token scanner with
// random idling and stalls, and gives the verdict from the checker's failure count
// depends on irts_pkg, ir_token_scanner_top and ir_token_scanner_checker
module ir_token_scanner_top_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import irts_pkg::*;

    localparam int TEXT_BYTES     = 600;   // bytes before the text is ended
    localparam int QUIET_FROM     = 480;   // no idling after this many bytes
    localparam int HOLD_AT        = 200;   // long receiver hold starts here
    localparam int DRAIN_AT       = 350;   // sender waits for all results here
    localparam int RX_HOLD_CYCLES = 64;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int TAIL_CYCLES    = 10;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       s_tvalid = 1'b0;
    logic [7:0] s_tdata = 8'h00;
    logic       s_tready;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic [4:0] m_tuser;
    logic       m_tlast;

    int   fail_cnt;
    int   pending;
    int   bytes_sent = 0;
    int   quiet_cycles = 0;
    logic tx_idles = 1'b1;
    logic rx_idles = 1'b1;
    logic long_hold_req = 1'b0;

    always #5 i_clk = ~i_clk;

    ir_token_scanner_top dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .o_m_axis_tlast  (m_tlast)
    );

    ir_token_scanner_checker u_checker (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .i_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .i_m_tdata  (m_tdata),
        .i_m_tuser  (m_tuser),
        .i_m_tlast  (m_tlast),
        .o_fail_cnt (fail_cnt),
        .o_pending  (pending)
    );

    // watchdog: any beat on either side restarts the count
    always @(posedge i_clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("ir_token_scanner_top regression: fail");
            $finish;
        end
    end

    // receiver: short random stalls, plus one long hold on request so the
    // result queue fills and the scanner backs up its input
    initial begin
        int stall_left;
        stall_left = 0;
        forever begin
            @(negedge i_clk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                stall_left    = RX_HOLD_CYCLES;
            end else if (stall_left == 0 && rx_idles && $urandom_range(0, 4) == 0) begin
                stall_left = $urandom_range(1, 3);
            end
            if (stall_left > 0) begin
                m_tready <= 1'b0;
                stall_left--;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // one text byte per beat; called and returns at a falling edge
    task automatic send_byte(input logic [7:0] b);
        if (tx_idles && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        do @(posedge i_clk); while (!s_tready);
        bytes_sent++;
        @(negedge i_clk);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_byte(s[i]);
    endtask

    function automatic logic [7:0] pick_letter();
        int r;
        r = $urandom_range(0, 52);
        if (r < 26)
            return 8'("A" + r);
        else if (r < 52)
            return 8'("a" + r - 26);
        return CH_UNDER;
    endfunction

    function automatic logic [7:0] pick_digit();
        return 8'("0" + $urandom_range(0, 9));
    endfunction

    function automatic logic [7:0] pick_alnum();
        return ($urandom_range(0, 2) == 0) ? pick_digit() : pick_letter();
    endfunction

    // a byte that cannot open a token, a blank or a zero: ends the text
    function automatic logic [7:0] pick_stray();
        logic [7:0] b;
        do begin
            b = 8'($urandom_range(1, 255));
        end while ((b >= "A" && b <= "Z") || (b >= "a" && b <= "z") || (b >= "0" && b <= "9")
                   || b == CH_UNDER || b == CH_DASH || b == CH_QUOTE || b == CH_PCT
                   || b == CH_DOLLAR || b == CH_SPACE || b == CH_NL);
        return b;
    endfunction

    // min_n to max_n blanks; zero means the next token abuts this one
    task automatic send_blanks(input int min_n, input int max_n);
        repeat ($urandom_range(min_n, max_n))
            send_byte($urandom_range(0, 1) ? CH_SPACE : CH_NL);
    endtask

    task automatic send_ident();
        int r;
        send_byte(pick_letter());
        repeat ($urandom_range(0, 6)) begin
            r = $urandom_range(0, 5);
            send_byte(r == 0 ? CH_DASH : pick_alnum());
        end
    endtask

    task automatic send_number();
        send_byte($urandom_range(0, 3) == 0 ? CH_DASH : pick_digit());
        repeat ($urandom_range(0, 5)) send_byte(pick_digit());
    endtask

    // any byte but quote and zero may sit inside a string
    task automatic send_quoted_body();
        logic [7:0] b;
        repeat ($urandom_range(0, 8)) begin
            do b = 8'($urandom_range(1, 255)); while (b == CH_QUOTE);
            send_byte(b);
        end
    endtask

    task automatic send_quoted();
        send_byte(CH_QUOTE);
        send_quoted_body();
        send_byte(CH_QUOTE);
    endtask

    task automatic send_register();
        send_byte(CH_PCT);
        repeat ($urandom_range(0, 5)) send_byte(pick_letter());
    endtask

    // an empty index gets a blank so no dash can follow the dollar sign
    task automatic send_index();
        int n;
        n = $urandom_range(0, 4);
        send_byte(CH_DOLLAR);
        repeat (n) send_byte(pick_alnum());
        if (n == 0)
            send_blanks(1, 1);
    endtask

    // loose token fragments; never a dollar sign or a quote
    task automatic send_fragments();
        int r;
        repeat ($urandom_range(1, 4)) begin
            r = $urandom_range(0, 5);
            case (r)
                0:       send_byte(CH_DASH);
                1:       send_byte(CH_PCT);
                2:       send_byte(CH_SPACE);
                3:       send_byte(pick_digit());
                default: send_byte(pick_letter());
            endcase
        end
    endtask

    // drop the last beat off the bus, then wait until every result is out
    task automatic wait_results_drained();
        s_tvalid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
    endtask

    initial begin
        logic hold_done;
        hold_done = 1'b0;
        repeat (12) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed text: identifier with digit and dash, register, index, string
        // with extreme bytes, dash-led number, empty register, empty index,
        // number closed by a letter; in the first run every closer opens the next token
        send_text("aZ_9-%z$A0\"");
        send_byte(8'h01);
        send_byte(8'hFF);
        send_byte(8'h80);
        send_text("\"-9% $\n9a ");

        // sender pause until every result of the directed text is out
        wait_results_drained();

        while (bytes_sent < TEXT_BYTES) begin
            if (!hold_done && bytes_sent >= HOLD_AT) begin
                long_hold_req = 1'b1;
                hold_done     = 1'b1;
            end
            if (bytes_sent >= DRAIN_AT && bytes_sent < DRAIN_AT + 8)
                wait_results_drained();
            if (bytes_sent >= QUIET_FROM) begin
                tx_idles = 1'b0;
                rx_idles = 1'b0;
            end
            case ($urandom_range(0, 9))
                0, 1:    send_ident();
                2, 3:    send_number();
                4:       send_quoted();
                5:       send_register();
                6:       send_index();
                7:       send_fragments();
                default: send_blanks(1, 2);
            endcase
            send_blanks(0, 2);
        end

        // end the text one of several ways
        case ($urandom_range(0, 4))
            0: begin
                send_byte(CH_SPACE);
                send_byte(CH_NUL);
            end
            1: begin
                // string still open at the zero byte
                send_byte(CH_SPACE);
                send_byte(CH_QUOTE);
                send_quoted_body();
                send_byte(CH_NUL);
            end
            2: begin
                send_byte(CH_SPACE);
                send_byte(CH_DOLLAR);
                send_byte(CH_DASH);
            end
            3: begin
                send_byte(CH_SPACE);
                send_byte(pick_stray());
            end
            default: begin
                // open token closed by the terminator
                send_byte(CH_SPACE);
                send_ident();
                send_byte($urandom_range(0, 1) ? CH_NUL : pick_stray());
            end
        endcase

        // text is finished: these are swallowed without results
        repeat ($urandom_range(3, 6)) send_byte(8'($urandom_range(0, 255)));

        wait_results_drained();
        repeat (TAIL_CYCLES) @(negedge i_clk);
        if (fail_cnt == 0)
            $display("ir_token_scanner_top regression: pass");
        else
            $display("ir_token_scanner_top regression: fail");
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/irts_pkg.sv
hw/rtl/irts_scan.sv
hw/rtl/irts_outq.sv
hw/rtl/ir_token_scanner_top.sv
hw/rtl/irts_checker.sv
tb/ir_token_scanner_checker.sv
tb/ir_token_scanner_top_tb.sv
